[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is held
`define FRSE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("frse assertion failed");

// Clocked check that also runs through reset
`define FRSE_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("frse reset assertion failed");

`endif

[sv/frse_pkg.sv]
// ----------------------------------------------------------------------------
// frse_pkg
// Types, constants and binary32 arithmetic helpers for the estimate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package frse_pkg;

    localparam logic [31:0] CANON_NAN   = 32'h7FC0_0000;
    localparam logic [31:0] POS_INF     = 32'h7F80_0000;
    localparam logic [31:0] RECIP_MAGIC = 32'h7EF3_11C3;
    localparam logic [31:0] RSQRT_MAGIC = 32'h5F37_5A86;
    localparam logic [31:0] FP_TWO      = 32'h4000_0000;
    localparam logic [31:0] FP_THREE_HALVES = 32'h3FC0_0000;
    localparam logic [31:0] FP_HALF     = 32'h3F00_0000;
    localparam logic [31:0] FP_ONE      = 32'h3F80_0000;

    localparam logic OP_RECIP = 1'b0;
    localparam logic OP_RSQRT = 1'b1;

    // Unrounded result: value = sig / 2^46 * 2^(exp - 127), sticky below bit 0
    typedef struct packed {
        logic               sp;
        logic [31:0]        sp_bits;
        logic               sign;
        logic signed [10:0] exp;
        logic [47:0]        sig;
        logic               sticky;
    } raw_t;

    // Normalized: leading one at bit 47, value = sig / 2^47 * 2^(exp - 127)
    typedef struct packed {
        logic               sp;
        logic [31:0]        sp_bits;
        logic               sign;
        logic signed [10:0] exp;
        logic [47:0]        sig;
        logic               sticky;
    } norm_t;

    // Per-item context riding alongside the datapath
    typedef struct packed {
        logic        op;
        logic        sign;
        logic        special;
        logic [31:0] sp_bits;
        logic [31:0] x;
        logic [31:0] e;
    } ctx_t;

    function automatic logic is_nan(input logic [31:0] f);
        is_nan = (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf(input logic [31:0] f);
        is_inf = (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
    endfunction

    function automatic logic is_zero(input logic [31:0] f);
        is_zero = (f[30:0] == 31'd0);
    endfunction

    function automatic logic [7:0] eff_exp(input logic [31:0] f);
        eff_exp = (f[30:23] == 8'd0) ? 8'd1 : f[30:23];
    endfunction

    function automatic raw_t fp_mul(input logic [31:0] a, input logic [31:0] b);
        raw_t        r;
        logic        s;
        logic [23:0] ma;
        logic [23:0] mb;
        s = a[31] ^ b[31];
        r = '0;
        r.sign = s;
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_zero(b))
                || (is_zero(a) && is_inf(b))) begin
            r.sp = 1'b1;
            r.sp_bits = CANON_NAN;
        end else if (is_inf(a) || is_inf(b)) begin
            r.sp = 1'b1;
            r.sp_bits = {s, POS_INF[30:0]};
        end else if (is_zero(a) || is_zero(b)) begin
            r.sp = 1'b1;
            r.sp_bits = {s, 31'd0};
        end else begin
            ma = {a[30:23] != 8'd0, a[22:0]};
            mb = {b[30:23] != 8'd0, b[22:0]};
            r.exp = $signed({3'b000, eff_exp(a)}) + $signed({3'b000, eff_exp(b)})
                    - 11'sd127;
            r.sig = {24'd0, ma} * {24'd0, mb};
        end
        return r;
    endfunction

    function automatic raw_t fp_add(input logic [31:0] a, input logic [31:0] b);
        raw_t        r;
        logic [31:0] big;
        logic [31:0] sml;
        logic [7:0]  d;
        logic [47:0] abig;
        logic [47:0] bsml;
        logic [47:0] bsh;
        logic        st;
        logic [48:0] sum;
        r = '0;
        big = (b[30:0] > a[30:0]) ? b : a;
        sml = (b[30:0] > a[30:0]) ? a : b;
        d = eff_exp(big) - eff_exp(sml);
        abig = {1'b0, big[30:23] != 8'd0, big[22:0], 23'd0};
        bsml = {1'b0, sml[30:23] != 8'd0, sml[22:0], 23'd0};
        if (d >= 8'd48) begin
            bsh = '0;
            st  = 1'b1;
        end else begin
            bsh = bsml >> d;
            st  = |(bsml & ((48'd1 << d) - 48'd1));
        end
        sum = (a[31] ^ b[31]) ? ({abig, 1'b0} - {bsh, st}) : ({abig, 1'b0} + {bsh, st});
        if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31])))
        begin
            r.sp = 1'b1;
            r.sp_bits = CANON_NAN;
        end else if (is_inf(a)) begin
            r.sp = 1'b1;
            r.sp_bits = a;
        end else if (is_inf(b)) begin
            r.sp = 1'b1;
            r.sp_bits = b;
        end else if (is_zero(a) && is_zero(b)) begin
            r.sp = 1'b1;
            r.sp_bits = {a[31] & b[31], 31'd0};
        end else if (is_zero(a)) begin
            r.sp = 1'b1;
            r.sp_bits = b;
        end else if (is_zero(b)) begin
            r.sp = 1'b1;
            r.sp_bits = a;
        end else if (sum == 49'd0) begin
            // exact cancellation rounds to +0
            r.sp = 1'b1;
            r.sp_bits = 32'd0;
        end else begin
            r.sign   = big[31];
            r.exp    = $signed({3'b000, eff_exp(big)});
            r.sig    = sum[48:1];
            r.sticky = sum[0];
        end
        return r;
    endfunction

    function automatic norm_t fp_norm(input raw_t r);
        norm_t      n;
        logic [5:0] lz;
        lz = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (r.sig[i]) begin
                lz = 6'(47 - i);
            end
        end
        n.sp      = r.sp || (r.sig == 48'd0);
        n.sp_bits = r.sp ? r.sp_bits : {r.sign, 31'd0};
        n.sign    = r.sign;
        n.exp     = r.exp + 11'sd1 - $signed({5'b00000, lz});
        n.sig     = r.sig << lz;
        n.sticky  = r.sticky;
        return n;
    endfunction

    function automatic logic [31:0] fp_round(input norm_t n);
        logic signed [10:0] shr;
        logic signed [10:0] em1;
        logic [5:0]         sh;
        logic [47:0]        shifted;
        logic               st;
        logic [24:0]        m25;
        logic [7:0]         ebase;
        logic [30:0]        mag;
        logic               inc;
        shr = 11'sd1 - n.exp;
        em1 = n.exp - 11'sd1;
        if (n.exp >= 11'sd1) begin
            sh = 6'd0;
        end else if (shr > 11'sd48) begin
            sh = 6'd48;
        end else begin
            sh = shr[5:0];
        end
        shifted = n.sig >> sh;
        st  = n.sticky | (|(n.sig & ((48'd1 << sh) - 48'd1))) | (|shifted[22:0]);
        inc = shifted[23] & (st | shifted[24]);
        m25 = {1'b0, shifted[47:24]} + {24'd0, inc};
        ebase = (n.exp >= 11'sd1) ? em1[7:0] : 8'd0;
        mag = {ebase, 23'd0} + {6'd0, m25};
        if (n.sp) begin
            fp_round = n.sp_bits;
        end else if (n.exp >= 11'sd255) begin
            fp_round = {n.sign, POS_INF[30:0]};
        end else begin
            fp_round = {n.sign, mag};
        end
    endfunction

endpackage

`default_nettype wire

[sv/frse_fmul.sv]
// ----------------------------------------------------------------------------
// frse_fmul
// Binary32 multiply front stage: specials and 24x24 significand product.
// ----------------------------------------------------------------------------
`default_nettype none

module frse_fmul (
    input  wire logic            aclk,
    input  wire logic            ce,
    input  wire logic [31:0]     a,
    input  wire logic [31:0]     b,
    output frse_pkg::raw_t       raw_reg
);

    frse_pkg::raw_t raw_next;

    assign raw_next = frse_pkg::fp_mul(a, b);

    always_ff @(posedge aclk) begin
        if (ce) begin
            raw_reg <= raw_next;
        end
    end

endmodule

`default_nettype wire

[sv/frse_fadd.sv]
// ----------------------------------------------------------------------------
// frse_fadd
// Binary32 add front stage: specials, alignment and significand add.
// ----------------------------------------------------------------------------
`default_nettype none

module frse_fadd (
    input  wire logic            aclk,
    input  wire logic            ce,
    input  wire logic [31:0]     a,
    input  wire logic [31:0]     b,
    output frse_pkg::raw_t       raw_reg
);

    frse_pkg::raw_t raw_next;

    assign raw_next = frse_pkg::fp_add(a, b);

    always_ff @(posedge aclk) begin
        if (ce) begin
            raw_reg <= raw_next;
        end
    end

endmodule

`default_nettype wire

[sv/frse_round.sv]
// ----------------------------------------------------------------------------
// frse_round
// Two-stage back end: leading-one normalize, then subnormal shift and RNE.
// ----------------------------------------------------------------------------
`default_nettype none

module frse_round (
    input  wire logic            aclk,
    input  wire logic            ce,
    input  wire frse_pkg::raw_t  raw,
    output logic [31:0]          res_reg
);

    frse_pkg::norm_t norm_reg;
    frse_pkg::norm_t norm_next;
    logic [31:0]     res_next;

    assign norm_next = frse_pkg::fp_norm(raw);
    assign res_next  = frse_pkg::fp_round(norm_reg);

    always_ff @(posedge aclk) begin
        if (ce) begin
            norm_reg <= norm_next;
            res_reg  <= res_next;
        end
    end

endmodule

`default_nettype wire

[sv/float_recip_rsqrt_estimate.sv]
// ----------------------------------------------------------------------------
// float_recip_rsqrt_estimate
// Binary32 reciprocal / reciprocal square root estimate, seed plus one Newton step.
// ----------------------------------------------------------------------------
// One beat in, one beat out. s_tuser selects the op (0 reciprocal, 1 rsqrt),
// s_tdata carries the binary32 operand. The unit takes a new beat every
// cycle except while the pipeline is frozen. The pipeline is 17 registers
// deep: a seed/special-case stage, five floating point operations of three
// stages each (multiply or align-add, normalize, round) and the output
// register. All stages advance together and freeze while m_tvalid is high
// and m_tready low, so s_tready is low only in that case. Every operation
// rounds to nearest even with subnormals kept, and any NaN result comes out
// as 0x7FC00000.
// ----------------------------------------------------------------------------
`default_nettype none

module float_recip_rsqrt_estimate (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] operand_bits
    input  wire logic [0:0]  s_tuser,   // [0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [31:0] result_bits
);

    localparam int Depth = 16;

    logic             ce;
    frse_pkg::ctx_t   ctx_next;
    frse_pkg::ctx_t   ctx_reg [Depth];
    logic [Depth-1:0] vld_reg;
    logic             out_vld_reg;
    logic [31:0]      out_reg;
    logic [31:0]      out_next;

    // per-op operands and results
    logic [31:0]    op1_a, op1_b, op2_b, op3_b, op4_a, op4_b;
    frse_pkg::raw_t raw1, raw2, raw3, raw4, raw5;
    logic [31:0]    t1, t2, t3, t4, t5;

    logic [31:0] x;
    logic [31:0] mag;
    logic        x_nan;

    // whole pipe moves unless the output beat is stuck
    assign ce       = !out_vld_reg || m_tready;
    assign s_tready = ce;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    // ---- seed and special cases ----
    assign x     = s_tdata;
    assign mag   = {1'b0, x[30:0]};
    assign x_nan = frse_pkg::is_nan(x);

    always_comb begin
        ctx_next.op      = s_tuser[0];
        ctx_next.sign    = x[31];
        ctx_next.x       = x;
        ctx_next.special = 1'b0;
        ctx_next.sp_bits = frse_pkg::CANON_NAN;
        if (s_tuser[0] == frse_pkg::OP_RSQRT) begin
            ctx_next.e = frse_pkg::RSQRT_MAGIC - {1'b0, x[31:1]};
            if (x_nan) begin
                ctx_next.special = 1'b1;
            end else if (mag == 32'd0) begin
                ctx_next.special = 1'b1;
                ctx_next.sp_bits = frse_pkg::POS_INF;
            end else if (x[31]) begin
                ctx_next.special = 1'b1;
            end else if (x == frse_pkg::POS_INF) begin
                ctx_next.special = 1'b1;
                ctx_next.sp_bits = 32'd0;
            end
        end else begin
            // seed may wrap into inf/NaN patterns; the ops handle that
            ctx_next.e = frse_pkg::RECIP_MAGIC - mag;
            if (x_nan) begin
                ctx_next.special = 1'b1;
            end else if (mag == 32'd0) begin
                ctx_next.special = 1'b1;
                ctx_next.sp_bits = {x[31], frse_pkg::POS_INF[30:0]};
            end else if (mag == frse_pkg::POS_INF) begin
                ctx_next.special = 1'b1;
                ctx_next.sp_bits = {x[31], 31'd0};
            end
        end
    end

    // ---- context / valid line ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (ce) begin
            vld_reg     <= {vld_reg[Depth-2:0], s_tvalid};
            out_vld_reg <= vld_reg[Depth-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ctx_reg[0] <= ctx_next;
            for (int i = 1; i < Depth; i++) begin
                ctx_reg[i] <= ctx_reg[i-1];
            end
            out_reg <= out_next;
        end
    end

    // ---- op 1: m*e (recip) or 0.5*x (rsqrt) ----
    assign op1_a = (ctx_reg[0].op == frse_pkg::OP_RSQRT) ? frse_pkg::FP_HALF
                                                          : {1'b0, ctx_reg[0].x[30:0]};
    assign op1_b = (ctx_reg[0].op == frse_pkg::OP_RSQRT) ? ctx_reg[0].x : ctx_reg[0].e;

    frse_fmul u_mul1 (.aclk(aclk), .ce(ce), .a(op1_a), .b(op1_b), .raw_reg(raw1));
    frse_round u_rnd1 (.aclk(aclk), .ce(ce), .raw(raw1), .res_reg(t1));

    // ---- ops 2 and 3: t*e for rsqrt, exact pass (times 1.0) for recip ----
    assign op2_b = (ctx_reg[3].op == frse_pkg::OP_RSQRT) ? ctx_reg[3].e : frse_pkg::FP_ONE;

    frse_fmul u_mul2 (.aclk(aclk), .ce(ce), .a(t1), .b(op2_b), .raw_reg(raw2));
    frse_round u_rnd2 (.aclk(aclk), .ce(ce), .raw(raw2), .res_reg(t2));

    assign op3_b = (ctx_reg[6].op == frse_pkg::OP_RSQRT) ? ctx_reg[6].e : frse_pkg::FP_ONE;

    frse_fmul u_mul3 (.aclk(aclk), .ce(ce), .a(t2), .b(op3_b), .raw_reg(raw3));
    frse_round u_rnd3 (.aclk(aclk), .ce(ce), .raw(raw3), .res_reg(t3));

    // ---- op 4: 2.0 - t or 1.5 - t ----
    assign op4_a = (ctx_reg[9].op == frse_pkg::OP_RSQRT) ? frse_pkg::FP_THREE_HALVES
                                                          : frse_pkg::FP_TWO;
    assign op4_b = {~t3[31], t3[30:0]};

    frse_fadd u_add4 (.aclk(aclk), .ce(ce), .a(op4_a), .b(op4_b), .raw_reg(raw4));
    frse_round u_rnd4 (.aclk(aclk), .ce(ce), .raw(raw4), .res_reg(t4));

    // ---- op 5: e*t ----
    frse_fmul u_mul5 (.aclk(aclk), .ce(ce), .a(ctx_reg[12].e), .b(t4), .raw_reg(raw5));
    frse_round u_rnd5 (.aclk(aclk), .ce(ce), .raw(raw5), .res_reg(t5));

    // ---- final select: specials, recip sign copy, NaN canonicalization ----
    always_comb begin
        if (ctx_reg[15].special) begin
            out_next = ctx_reg[15].sp_bits;
        end else if (frse_pkg::is_nan(t5)) begin
            out_next = frse_pkg::CANON_NAN;
        end else if (ctx_reg[15].op == frse_pkg::OP_RECIP) begin
            out_next = {ctx_reg[15].sign, t5[30:0]};
        end else begin
            out_next = t5;
        end
    end

endmodule

`default_nettype wire

[sv/frse_checker.sv]
// ----------------------------------------------------------------------------
// frse_checker
// Port-level checks for the estimate unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module frse_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [31:0] s_tdata,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    logic nan_out;

    assign nan_out = (m_tdata[30:23] == 8'hFF) && (m_tdata[22:0] != 23'd0);

    `FRSE_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `FRSE_ASSERT(a_ready, s_tready == (!m_tvalid || m_tready))
    `FRSE_ASSERT(a_canon, m_tvalid && nan_out |-> m_tdata == frse_pkg::CANON_NAN)
    `FRSE_ASSERT_RST(a_rst, !aresetn |=> !m_tvalid)

endmodule

bind float_recip_rsqrt_estimate frse_checker u_frse_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);

`default_nettype wire
